/* src/dscbp_pkg.sv */
// ----------------------------------------------------------------------------
// dscbp_pkg: shared types and constants of the delta size-code bit packer
// Holds the transaction structs of both channels, the queue entry that
// travels from the front end to the packer, and the size-code helpers.
// ----------------------------------------------------------------------------
package dscbp_pkg;

    localparam int SAMPLE_W   = 64;
    localparam int HALF_W     = 32;
    localparam int WORD_W     = 32;
    localparam int CODE_W     = 2;
    localparam int LEN_W      = 7;
    localparam int FILL_W     = 5;
    localparam int KIND_W     = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Largest number of results one input can cause, and the slot index width.
    localparam int JOB_DEPTH  = 5;
    localparam int JOB_IDX_W  = $clog2(JOB_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_CONTROL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd2;

    localparam logic [CODE_W-1:0] CODE_ZERO = 2'd0;
    localparam logic [CODE_W-1:0] CODE_B16  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_B24  = 2'd2;
    localparam logic [CODE_W-1:0] CODE_B32  = 2'd3;

    localparam logic [HALF_W:0] LIMIT_B16 = 33'h1_0000;
    localparam logic [HALF_W:0] LIMIT_B24 = 33'h100_0000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [KIND_W-1:0] kind;
        logic              run_end;
    } t_out;

    // One classified item: both size codes, the data bits of both halves
    // placed back to back from bit 0, and their total length.
    typedef struct packed {
        logic [2*CODE_W-1:0]   codes;
        logic [SAMPLE_W-1:0]   bits;
        logic [LEN_W-1:0]      len;
        logic                  last;
    } t_entry;

    function automatic logic [CODE_W-1:0] size_code(input logic [HALF_W-1:0] v);
        logic [HALF_W:0] ext;
        logic [CODE_W-1:0] code;
        ext = {1'b0, v};
        if (v == '0) begin
            code = CODE_ZERO;
        end else if (ext < LIMIT_B16) begin
            code = CODE_B16;
        end else if (ext < LIMIT_B24) begin
            code = CODE_B24;
        end else begin
            code = CODE_B32;
        end
        return code;
    endfunction

    function automatic logic [LEN_W-1:0] code_bits(input logic [CODE_W-1:0] code);
        logic [LEN_W-1:0] n;
        unique case (code)
            CODE_ZERO: n = 7'd0;
            CODE_B16:  n = 7'd16;
            CODE_B24:  n = 7'd24;
            default:   n = 7'd32;
        endcase
        return n;
    endfunction

endpackage

/* src/dscbp_front.sv */
// ----------------------------------------------------------------------------
// dscbp_front: delta former and classifier
// Forms the delta from the previous sample, gives each half its size code
// and lines the data bits of both halves up into one queue entry.
// ----------------------------------------------------------------------------
module dscbp_front
    import dscbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_in    i_item,
    output t_entry o_entry
);

    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] delta;
    logic [HALF_W-1:0]   lo;
    logic [HALF_W-1:0]   hi;
    logic [CODE_W-1:0]   code_lo;
    logic [CODE_W-1:0]   code_hi;
    logic [LEN_W-1:0]    n_lo;
    logic [LEN_W-1:0]    n_hi;

    always_comb begin
        delta   = i_item.sample - r_prev;
        lo      = delta[HALF_W-1:0];
        hi      = delta[SAMPLE_W-1:HALF_W];
        code_lo = size_code(lo);
        code_hi = size_code(hi);
        n_lo    = code_bits(code_lo);
        n_hi    = code_bits(code_hi);
        // Each half is below 2^nbits, so no masking is needed.
        o_entry.codes = {code_hi, code_lo};
        o_entry.bits  = {{HALF_W{1'b0}}, lo} | ({{HALF_W{1'b0}}, hi} << n_lo);
        o_entry.len   = n_lo + n_hi;
        o_entry.last  = i_item.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_accept) begin
            r_prev <= i_item.last ? '0 : i_item.sample;
        end
    end

endmodule

/* src/dscbp_fifo.sv */
// ----------------------------------------------------------------------------
// dscbp_fifo: short queue between the front end and the packer
// Register-based first-in first-out store of classified items.
// ----------------------------------------------------------------------------
module dscbp_fifo
    import dscbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_wr_data,
    output logic   o_full,
    input  logic   i_rd,
    output t_entry o_rd_data,
    output logic   o_empty
);

    t_entry                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_wr;
    logic                  do_rd;

    assign o_full    = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/dscbp_back.sv */
// ----------------------------------------------------------------------------
// dscbp_back: bit packer and result sequencer
// Packs codes and data bits into 32-bit words, builds the list of results
// of one item and hands them out one per cycle, while results are popped, through an output register.
// ----------------------------------------------------------------------------
module dscbp_back
    import dscbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_entry i_head,
    input  logic   i_head_valid,
    output logic   o_take,
    output t_out   o_out,
    output logic   o_empty,
    input  logic   i_pop
);

    logic [WORD_W-1:0]    r_cacc;
    logic [FILL_W-1:0]    r_cfill;
    logic [WORD_W-1:0]    r_dacc;
    logic [FILL_W-1:0]    r_dfill;
    logic [WORD_W-1:0]    r_count;

    logic [WORD_W-1:0]    r_job_word [JOB_DEPTH];
    logic [KIND_W-1:0]    r_job_kind [JOB_DEPTH];
    logic [JOB_IDX_W-1:0] r_job_n;
    logic [JOB_IDX_W-1:0] r_job_idx;

    t_out                 r_out;
    logic                 r_out_valid;

    logic [WORD_W+3:0]    cval;
    logic [5:0]           csum;
    logic                 have_cw;
    logic [3*WORD_W-1:0]  dval;
    logic [LEN_W-1:0]     dtot;
    logic [WORD_W-1:0]    drem;
    logic [WORD_W-1:0]    c_word [JOB_DEPTH];
    logic [KIND_W-1:0]    c_kind [JOB_DEPTH];
    logic [JOB_DEPTH-1:0] c_en;
    logic [WORD_W-1:0]    n_job_word [JOB_DEPTH];
    logic [KIND_W-1:0]    n_job_kind [JOB_DEPTH];
    logic [JOB_IDX_W-1:0] n_job_n;

    logic job_left;
    logic out_free;
    logic move;
    logic final_move;
    logic take;

    assign job_left   = (r_job_idx != r_job_n);
    assign out_free   = !r_out_valid || i_pop;
    assign move       = out_free && job_left;
    assign final_move = (r_job_idx + 1'b1 == r_job_n);
    assign take       = (!job_left || (move && final_move)) && i_head_valid;
    assign o_take     = take;
    assign o_out      = r_out;
    assign o_empty    = !r_out_valid;

    always_comb begin
        // Control word: two codes enter at the fill point; a word is done
        // when the fill reaches 32, the overflow code stays behind.
        cval    = {4'd0, r_cacc} | ({{WORD_W{1'b0}}, i_head.codes} << r_cfill);
        csum    = {1'b0, r_cfill} + 6'd4;
        have_cw = csum[5];

        dval = {{2*WORD_W{1'b0}}, r_dacc} | ({{WORD_W{1'b0}}, i_head.bits} << r_dfill);
        dtot = {2'd0, r_dfill} + i_head.len;
        unique case (dtot[6:5])
            2'd0:    drem = dval[WORD_W-1:0];
            2'd1:    drem = dval[2*WORD_W-1:WORD_W];
            default: drem = dval[3*WORD_W-1:2*WORD_W];
        endcase

        c_word[0] = cval[WORD_W-1:0];
        c_kind[0] = KIND_CONTROL;
        c_en[0]   = have_cw || (i_head.last && csum[4:0] != '0);
        c_word[1] = dval[WORD_W-1:0];
        c_kind[1] = KIND_DATA;
        c_en[1]   = (dtot[6:5] != 2'd0);
        c_word[2] = dval[2*WORD_W-1:WORD_W];
        c_kind[2] = KIND_DATA;
        c_en[2]   = dtot[6];
        c_word[3] = drem;
        c_kind[3] = KIND_DATA;
        c_en[3]   = i_head.last && (dtot[4:0] != '0);
        c_word[4] = r_count + 1'b1;
        c_kind[4] = KIND_COUNT;
        c_en[4]   = i_head.last;

        // Close up the enabled results in their fixed order.
        n_job_n = '0;
        for (int i = 0; i < JOB_DEPTH; i++) begin
            n_job_word[i] = '0;
            n_job_kind[i] = KIND_CONTROL;
        end
        for (int i = 0; i < JOB_DEPTH; i++) begin
            if (c_en[i]) begin
                n_job_word[n_job_n] = c_word[i];
                n_job_kind[n_job_n] = c_kind[i];
                n_job_n             = n_job_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int i = 0; i < JOB_DEPTH; i++) begin
                r_job_word[i] <= n_job_word[i];
                r_job_kind[i] <= n_job_kind[i];
            end
        end
        if (out_free) begin
            r_out.word    <= r_job_word[r_job_idx];
            r_out.kind    <= r_job_kind[r_job_idx];
            r_out.run_end <= final_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cacc      <= '0;
            r_cfill     <= '0;
            r_dacc      <= '0;
            r_dfill     <= '0;
            r_count     <= '0;
            r_job_n     <= '0;
            r_job_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= job_left;
            end
            if (take) begin
                r_job_n   <= n_job_n;
                r_job_idx <= '0;
                if (i_head.last) begin
                    r_cacc  <= '0;
                    r_cfill <= '0;
                    r_dacc  <= '0;
                    r_dfill <= '0;
                    r_count <= '0;
                end else begin
                    r_cacc  <= have_cw ? {28'd0, cval[WORD_W+3:WORD_W]} : cval[WORD_W-1:0];
                    r_cfill <= csum[4:0];
                    r_dacc  <= drem;
                    r_dfill <= dtot[4:0];
                    r_count <= r_count + 1'b1;
                end
            end else if (move) begin
                r_job_idx <= r_job_idx + 1'b1;
            end
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_idx <= r_job_n && r_job_n <= JOB_IDX_W'(JOB_DEPTH))
        else $error("result index ran past the job length");

    a_cfill_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfill[0])
        else $error("control fill lost its two-bit alignment");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_head.last |=> r_count == '0 && r_cfill == '0 && r_dfill == '0)
        else $error("state not cleared after the final item of a run");

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> i_head_valid && (!job_left || final_move))
        else $error("new item taken while results of the previous one remain");

endmodule

/* src/delta_size_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// delta_size_code_bit_packer: streaming delta size-code bit packer
// Encodes 64-bit samples as deltas with 2-bit size codes per 32-bit half and
// packs the codes and data bits into 32-bit control and data words.
//
//   Channel   Handshake           Payload fields             Direction
//   input     push / full         sample[63:0], last         into the block
//   result    empty / pop         word[31:0], kind, run_end  out of the block
//
// A transaction enters the front end and is queued; the packer takes a
// queued item, drains its results one per cycle while the result side pops,
// and takes the next item as the last result (of up to 5) moves into the
// single-word result register; items with no results are taken one per cycle.
// Reset is synchronous and active low; after it the run state is zero and
// the first delta is taken from zero. Input and result sides stall
// independently: a full queue raises full, and a held result does not stop
// items from entering until the queue fills.
// ----------------------------------------------------------------------------
module delta_size_code_bit_packer
    import dscbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_data,
    output logic empty,
    input  logic pop,
    output t_out o_data
);

    // An input transaction is accepted when push is high and the queue has room.
    logic   accept;
    t_entry front_entry;
    t_entry head;
    logic   fifo_empty;
    logic   take;

    assign accept = push && !full;

    // Front end: delta, size codes and data bit alignment.
    dscbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_entry  (front_entry)
    );

    // Short queue that lets the front end and the packer stall separately.
    dscbp_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_entry),
        .o_full    (full),
        .i_rd      (take),
        .o_rd_data (head),
        .o_empty   (fifo_empty)
    );

    // Packer: accumulates codes and data bits, then hands out each result
    // transaction through the output register.
    dscbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!fifo_empty),
        .o_take       (take),
        .o_out        (o_data),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for the delta size-code bit packer
// Pushes 64-bit samples in runs, each closed by a last flag, and compares
// every popped control, data and count word with a local packing model or
// a hand-written table. A directed table opens the test, and random runs
// with a share of noise follow. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import dscbp_pkg::*;

    localparam int RANDOM_ITEMS = 310;
    localparam int ROW_N        = 24;
    localparam int TYPED_N      = 12;
    localparam int MAX_GAP      = 16;
    localparam int DRAIN_CYCLES = 32;

    // One directed row: the input transaction, followed by how many of its
    // results are typed in below. Zero means the packing model predicts them.
    typedef struct packed {
        t_in        item;
        logic [2:0] n_typed;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_data  = '0;
    logic full;
    logic empty;
    t_out o_data;

    // State of the packing model, a copy of the block's run state.
    logic [63:0] prev_sample;
    logic [31:0] code_acc;
    logic [31:0] data_acc;
    logic [31:0] run_count;
    int          code_fill;
    int          data_fill;

    // Words that the current sample completes, gathered while it is packed.
    logic [31:0] done_code;
    bit          code_done;
    logic [31:0] done_data[$];
    t_out        sample_words[$];

    // Results still owed by the block, oldest first.
    t_out        expected_words[$];
    int          error_count = 0;

    // While a side is quiet it neither idles nor stalls.
    bit          in_quiet  = 1'b0;
    bit          out_quiet = 1'b0;

    // The first four rows each form a run of one sample, so their results can
    // be written down by hand. Then comes a run over the size-code boundaries,
    // wrapping deltas, a repeated sample and a flush with partial words. The
    // last eight rows fill exactly one control word and four data words, so
    // the final sample of that run leaves nothing partial to flush.
    t_row dir_rows [ROW_N] = '{
        {64'h0000_0000_0000_0000, 1'b1, 3'd2},
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'd4},
        {64'h0000_0000_0000_0001, 1'b1, 3'd3},
        {64'h0000_0001_0000_0000, 1'b1, 3'd3},
        {64'h0000_0000_0000_FFFF, 1'b0, 3'd0},
        {64'h0000_0000_0001_FFFF, 1'b0, 3'd0},
        {64'h0000_0000_0100_FFFE, 1'b0, 3'd0},
        {64'h0000_0000_0200_FFFE, 1'b0, 3'd0},
        {64'h0000_FFFF_0200_FFFE, 1'b0, 3'd0},
        {64'h0000_FFFF_0200_FFFD, 1'b0, 3'd0},
        {64'h0000_0000_0000_0000, 1'b0, 3'd0},
        {64'h8000_0000_0000_0000, 1'b0, 3'd0},
        {64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 3'd0},
        {64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 3'd0},
        {64'hDEAD_BEEF_0123_4567, 1'b0, 3'd0},
        {64'h1234_5678_9ABC_DEF0, 1'b1, 3'd0},
        {64'h0000_0000_0000_0001, 1'b0, 3'd0},
        {64'h0000_0000_0000_0002, 1'b0, 3'd0},
        {64'h0000_0000_0000_0003, 1'b0, 3'd0},
        {64'h0000_0000_0000_0004, 1'b0, 3'd0},
        {64'h0000_0000_0000_0005, 1'b0, 3'd0},
        {64'h0000_0000_0000_0006, 1'b0, 3'd0},
        {64'h0000_0000_0000_0007, 1'b0, 3'd0},
        {64'h0000_0000_0000_0008, 1'b1, 3'd0}
    };

    // Hand-written results of the first four rows, in row order.
    t_out typed_results [TYPED_N] = '{
        {32'h0000_0000, KIND_CONTROL, 1'b0},
        {32'h0000_0001, KIND_COUNT,   1'b1},
        {32'h0000_000F, KIND_CONTROL, 1'b0},
        {32'hFFFF_FFFF, KIND_DATA,    1'b0},
        {32'hFFFF_FFFF, KIND_DATA,    1'b0},
        {32'h0000_0001, KIND_COUNT,   1'b1},
        {32'h0000_0001, KIND_CONTROL, 1'b0},
        {32'h0000_0001, KIND_DATA,    1'b0},
        {32'h0000_0001, KIND_COUNT,   1'b1},
        {32'h0000_0004, KIND_CONTROL, 1'b0},
        {32'h0000_0001, KIND_DATA,    1'b0},
        {32'h0000_0001, KIND_COUNT,   1'b1}
    };

    delta_size_code_bit_packer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Return the packing model to the start of a run.
    function automatic void clear_run();
        prev_sample = '0;
        code_acc    = '0;
        data_acc    = '0;
        run_count   = '0;
        code_fill   = 0;
        data_fill   = 0;
    endfunction

    // Classify one 32-bit half of a delta, append its size code to the
    // control accumulator and its data bits to the data accumulator.
    function automatic void pack_half(input logic [31:0] v);
        logic [1:0]  code;
        int          nbits;
        logic [63:0] acc;
        logic [63:0] mask;
        if (v == '0) begin
            code  = CODE_ZERO;
            nbits = 0;
        end else if (v < 32'h0001_0000) begin
            code  = CODE_B16;
            nbits = 16;
        end else if (v < 32'h0100_0000) begin
            code  = CODE_B24;
            nbits = 24;
        end else begin
            code  = CODE_B32;
            nbits = 32;
        end
        code_acc  = code_acc | (32'(code) << code_fill);
        code_fill = code_fill + 2;
        if (code_fill == 32) begin
            done_code = code_acc;
            code_done = 1'b1;
            code_acc  = '0;
            code_fill = 0;
        end
        if (nbits != 0) begin
            mask      = (64'h1 << nbits) - 64'h1;
            acc       = {32'h0, data_acc} | (({32'h0, v} & mask) << data_fill);
            data_fill = data_fill + nbits;
            if (data_fill >= 32) begin
                done_data.push_back(acc[31:0]);
                acc       = acc >> 32;
                data_fill = data_fill - 32;
            end
            data_acc = acc[31:0];
        end
    endfunction

    // Pack one accepted sample and leave its results, in output order, in
    // sample_words. A final sample also flushes partial words and the count.
    function automatic void pack_sample(input t_in it);
        logic [63:0] delta;
        delta     = it.sample - prev_sample;
        code_done = 1'b0;
        done_data.delete();
        sample_words.delete();
        pack_half(delta[31:0]);
        pack_half(delta[63:32]);
        prev_sample = it.sample;
        run_count   = run_count + 32'd1;
        if (it.last) begin
            if (!code_done && code_fill != 0) begin
                done_code = code_acc;
                code_done = 1'b1;
            end
            if (data_fill != 0) begin
                done_data.push_back(data_acc);
            end
        end
        if (code_done) begin
            sample_words.push_back('{done_code, KIND_CONTROL, 1'b0});
        end
        foreach (done_data[i]) begin
            sample_words.push_back('{done_data[i], KIND_DATA, 1'b0});
        end
        if (it.last) begin
            sample_words.push_back('{run_count, KIND_COUNT, 1'b0});
            clear_run();
        end
        if (sample_words.size() > 0) begin
            sample_words[sample_words.size() - 1].run_end = 1'b1;
        end
    endfunction

    // One half of a random delta with a chosen size code. Range ends are
    // picked now and then so that every boundary of the classifier is hit.
    function automatic logic [31:0] half_value(input int code);
        bit edge_pick;
        edge_pick = ($urandom_range(0, 7) == 0);
        case (code)
            0: return '0;
            1: return edge_pick ? (($urandom_range(0, 1) != 0) ? 32'h1 : 32'hFFFF)
                                : $urandom_range(1, 32'hFFFF);
            2: return edge_pick ? (($urandom_range(0, 1) != 0) ? 32'h1_0000 : 32'hFF_FFFF)
                                : $urandom_range(32'h1_0000, 32'hFF_FFFF);
            default: return edge_pick ? (($urandom_range(0, 1) != 0) ? 32'h100_0000
                                                                      : 32'hFFFF_FFFF)
                                      : $urandom_range(32'h100_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    // Offer one transaction on the input side and hold it until accepted.
    // The push line is lowered only when an idle gap is drawn, so a sample
    // that follows back to back keeps push high without a glitch.
    task automatic send_item(input t_in it);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            in_quiet = !in_quiet;
        end
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (full);
    endtask

    // Compare one popped result with the oldest outstanding expectation.
    task automatic check_result(input t_out got);
        t_out want;
        if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, got word %h kind %0d run_end %0b",
                     $time, got.word, got.kind, got.run_end);
            return;
        end
        want = expected_words.pop_front();
        if (got.word !== want.word) begin
            error_count++;
            $display("%0t: word mismatch: expected %h, got %h", $time, want.word, got.word);
        end
        if (got.kind !== want.kind) begin
            error_count++;
            $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, got.kind);
        end
        if (got.run_end !== want.run_end) begin
            error_count++;
            $display("%0t: run_end mismatch: expected %0b, got %0b",
                     $time, want.run_end, got.run_end);
        end
    endtask

    // Result side: draw a stall for every transaction, then pop until one
    // is taken. Values are read right after the edge, before the block's
    // registers move, so they are the ones that the edge accepted.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                out_quiet = !out_quiet;
            end
            gap = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            check_result(o_data);
        end
    end

    // Stimulus: the directed table, then random runs. Expectations are queued
    // in the step where the sample is accepted; no result of that sample can
    // leave the block before the next edge.
    initial begin
        int   typed_ptr;
        int   sent;
        int   run_len;
        t_in  it;
        logic [63:0] delta;
        clear_run();
        typed_ptr = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item);
            pack_sample(dir_rows[r].item);
            if (dir_rows[r].n_typed != 0) begin
                repeat (dir_rows[r].n_typed) begin
                    expected_words.push_back(typed_results[typed_ptr]);
                    typed_ptr++;
                end
            end else begin
                foreach (sample_words[i]) begin
                    expected_words.push_back(sample_words[i]);
                end
            end
        end

        // Random runs. Most are short so that many flushes occur; a few are
        // long enough to wrap several control words. About one sample in six
        // is raw noise with an arbitrary 64-bit value.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 24);
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    it.sample = {$urandom(), $urandom()};
                end else begin
                    delta = {half_value($urandom_range(0, 3)),
                             half_value($urandom_range(0, 3))};
                    if ($urandom_range(0, 7) == 0) begin
                        delta = -delta;
                    end
                    it.sample = prev_sample + delta;
                end
                it.last = (k == run_len - 1) || (sent == RANDOM_ITEMS - 1);
                send_item(it);
                pack_sample(it);
                foreach (sample_words[i]) begin
                    expected_words.push_back(sample_words[i]);
                end
                sent++;
            end
        end
        push <= 1'b0;

        // Wait for the last owed result, then give any stray result time to
        // show up before the verdict.
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("delta_size_code_bit_packer regression: pass");
        end else begin
            $display("delta_size_code_bit_packer regression: fail");
        end
        $finish;
    end

    // Watchdog. The slowest correct run is about 334 samples, each waiting out
    // an idle gap to enter and causing up to 5 results that each wait out a
    // stall to leave. The time limit allows several times that worst case.
    initial begin
        #2_000_000;
        $display("delta_size_code_bit_packer regression: fail");
        $finish;
    end

endmodule
